[rtl/elg_dec_pkg.sv]
// shared constants for the elgamal decryption block
// register indexes, reset values and field widths; no dependencies

package elg_dec_pkg;

   localparam int KEY_WIDTH_DEF = 16;
   localparam int FIELD_WIDTH   = 16;
   localparam int CSR_IDX_WIDTH = 2;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MODULUS    = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_GENERATOR  = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SECRET     = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SENDER_KEY = 2'd3;

   localparam int RST_MODULUS    = 59;
   localparam int RST_GENERATOR  = 2;
   localparam int RST_SECRET     = 5;
   localparam int RST_SENDER_KEY = 16;

endpackage

[rtl/elgamal_decrypt_top.sv]
// elgamal decryption top level: csr bank, sequencer and one shared modular multiplier
// depends on elg_dec_pkg
//
// channel   ports                                        handshake
// req       start, busy, req_ciphertext                  taken when start and not busy
// rsp       rsp_valid, rsp_plaintext, rsp_own_public_key,  one-cycle strobe
//           rsp_secret_invalid
// csr       csr_write_enable, csr_index, csr_write_data  written on every enabled edge
//
// every modular multiply runs msb-first over OW = max(KEY_WIDTH, 16) bits, one bit a cycle,
// and then returns to the state that started it, which takes the result
// a word runs two exponentiations through the shared multiplier, with the exponents
// secret*(p-2) and secret; the result strobe comes in the first cycle with busy low
// a zero modulus keeps busy high for one cycle only
// reset is synchronous and restores the register reset values; the receiver cannot stall

module elgamal_decrypt_top
   import elg_dec_pkg::*;
#(
   parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [FIELD_WIDTH-1:0]   req_ciphertext,
   output logic                     rsp_valid,
   output logic [FIELD_WIDTH-1:0]   rsp_plaintext,
   output logic [FIELD_WIDTH-1:0]   rsp_own_public_key,
   output logic                     rsp_secret_invalid,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [KEY_WIDTH-1:0]     csr_write_data
);

   localparam int OW = (KEY_WIDTH > FIELD_WIDTH) ? KEY_WIDTH : FIELD_WIDTH;
   localparam int EW = 2 * KEY_WIDTH;
   localparam int CW = $clog2(OW);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MM,
      S_BASE_SET,
      S_EXP,
      S_ACC_SET,
      S_SQR_SET,
      S_CMOD_SET,
      S_PLAIN_SET,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   logic [KEY_WIDTH-1:0]   modulus_ff, modulus_in;
   logic [KEY_WIDTH-1:0]   generator_ff, generator_in;
   logic [KEY_WIDTH-1:0]   secret_ff, secret_in;
   logic [KEY_WIDTH-1:0]   sender_ff, sender_in;

   logic [FIELD_WIDTH-1:0] cipher_ff, cipher_in;
   logic [EW-1:0]          exp_ff, exp_in;
   logic                   phase_ff, phase_in;
   logic [KEY_WIDTH-1:0]   base_ff, base_in;
   logic [KEY_WIDTH-1:0]   acc_ff, acc_in;
   logic [OW-1:0]          mm_a_ff, mm_a_in;
   logic [KEY_WIDTH-1:0]   mm_b_ff, mm_b_in;
   logic [KEY_WIDTH-1:0]   mm_r_ff, mm_r_in;
   logic [CW-1:0]          mm_cnt_ff, mm_cnt_in;
   logic [FIELD_WIDTH-1:0] plain_ff, plain_in;
   logic [FIELD_WIDTH-1:0] own_ff, own_in;
   logic                   bad_ff, bad_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // shared modular multiply step
   logic [KEY_WIDTH:0]     mm_mod;
   logic [KEY_WIDTH:0]     mm_dbl;
   logic [KEY_WIDTH:0]     mm_red1;
   logic [KEY_WIDTH:0]     mm_sum;
   logic [KEY_WIDTH:0]     mm_red2;
   logic [KEY_WIDTH-1:0]   mm_next;

   logic [KEY_WIDTH-1:0]   one_val;
   logic [KEY_WIDTH-1:0]   pm2;
   logic [OW-1:0]          res_ext;
   logic [OW-1:0]          acc_ext;

   assign mm_mod  = {1'b0, modulus_ff};
   assign mm_dbl  = {mm_r_ff, 1'b0};
   assign mm_red1 = (mm_dbl >= mm_mod) ? (mm_dbl - mm_mod) : mm_dbl;
   assign mm_sum  = mm_red1 + (mm_a_ff[OW-1] ? {1'b0, mm_b_ff} : '0);
   assign mm_red2 = (mm_sum >= mm_mod) ? (mm_sum - mm_mod) : mm_sum;
   assign mm_next = mm_red2[KEY_WIDTH-1:0];

   assign one_val = (modulus_ff == KEY_WIDTH'(1)) ? '0 : KEY_WIDTH'(1);
   assign pm2     = (modulus_ff >= KEY_WIDTH'(2)) ? (modulus_ff - KEY_WIDTH'(2)) : '0;
   assign res_ext = OW'(mm_r_ff);
   assign acc_ext = OW'(acc_ff);

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      modulus_in   = modulus_ff;
      generator_in = generator_ff;
      secret_in    = secret_ff;
      sender_in    = sender_ff;
      cipher_in    = cipher_ff;
      exp_in       = exp_ff;
      phase_in     = phase_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      mm_a_in      = mm_a_ff;
      mm_b_in      = mm_b_ff;
      mm_r_in      = mm_r_ff;
      mm_cnt_in    = mm_cnt_ff;
      plain_in     = plain_ff;
      own_in       = own_ff;
      bad_in       = bad_ff;
      rsp_valid_in = 1'b0;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_MODULUS:    modulus_in   = csr_write_data;
            CSR_GENERATOR:  generator_in = csr_write_data;
            CSR_SECRET:     secret_in    = csr_write_data;
            CSR_SENDER_KEY: sender_in    = csr_write_data;
            default:        ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cipher_in = req_ciphertext;
               bad_in    = (secret_ff == '0) || (secret_ff >= modulus_ff);
               exp_in    = EW'(secret_ff) * EW'(pm2);
               phase_in  = 1'b0;
               if (modulus_ff == '0) begin
                  plain_in = '0;
                  own_in   = '0;
                  state_in = S_DONE;
               end else begin
                  // reduce sender key
                  mm_a_in   = OW'(sender_ff);
                  mm_b_in   = one_val;
                  mm_r_in   = '0;
                  mm_cnt_in = CW'(OW - 1);
                  ret_in    = S_BASE_SET;
                  state_in  = S_MM;
               end
            end
         end
         S_MM: begin
            mm_r_in   = mm_next;
            mm_a_in   = mm_a_ff << 1;
            mm_cnt_in = mm_cnt_ff - CW'(1);
            if (mm_cnt_ff == '0) begin
               state_in = ret_ff;
            end
         end
         S_BASE_SET: begin
            base_in  = mm_r_ff;
            acc_in   = one_val;
            state_in = S_EXP;
         end
         S_EXP: begin
            mm_r_in   = '0;
            mm_cnt_in = CW'(OW - 1);
            if (exp_ff == '0) begin
               if (!phase_ff) begin
                  // reduce ciphertext
                  mm_a_in  = OW'(cipher_ff);
                  mm_b_in  = one_val;
                  ret_in   = S_CMOD_SET;
                  state_in = S_MM;
               end else begin
                  own_in   = acc_ext[FIELD_WIDTH-1:0];
                  state_in = S_DONE;
               end
            end else if (exp_ff[0]) begin
               mm_a_in  = OW'(acc_ff);
               mm_b_in  = base_ff;
               ret_in   = S_ACC_SET;
               state_in = S_MM;
            end else begin
               mm_a_in  = OW'(base_ff);
               mm_b_in  = base_ff;
               ret_in   = S_SQR_SET;
               state_in = S_MM;
            end
         end
         S_ACC_SET: begin
            acc_in    = mm_r_ff;
            mm_a_in   = OW'(base_ff);
            mm_b_in   = base_ff;
            mm_r_in   = '0;
            mm_cnt_in = CW'(OW - 1);
            ret_in    = S_SQR_SET;
            state_in  = S_MM;
         end
         S_SQR_SET: begin
            base_in  = mm_r_ff;
            exp_in   = exp_ff >> 1;
            state_in = S_EXP;
         end
         S_CMOD_SET: begin
            // inverse times reduced ciphertext
            mm_a_in   = OW'(acc_ff);
            mm_b_in   = mm_r_ff;
            mm_r_in   = '0;
            mm_cnt_in = CW'(OW - 1);
            ret_in    = S_PLAIN_SET;
            state_in  = S_MM;
         end
         S_PLAIN_SET: begin
            plain_in  = res_ext[FIELD_WIDTH-1:0];
            phase_in  = 1'b1;
            exp_in    = EW'(secret_ff);
            mm_a_in   = OW'(generator_ff);
            mm_b_in   = one_val;
            mm_r_in   = '0;
            mm_cnt_in = CW'(OW - 1);
            ret_in    = S_BASE_SET;
            state_in  = S_MM;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= KEY_WIDTH'(RST_MODULUS);
         generator_ff <= KEY_WIDTH'(RST_GENERATOR);
         secret_ff    <= KEY_WIDTH'(RST_SECRET);
         sender_ff    <= KEY_WIDTH'(RST_SENDER_KEY);
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         modulus_ff   <= modulus_in;
         generator_ff <= generator_in;
         secret_ff    <= secret_in;
         sender_ff    <= sender_in;
      end
      cipher_ff <= cipher_in;
      exp_ff    <= exp_in;
      phase_ff  <= phase_in;
      base_ff   <= base_in;
      acc_ff    <= acc_in;
      mm_a_ff   <= mm_a_in;
      mm_b_ff   <= mm_b_in;
      mm_r_ff   <= mm_r_in;
      mm_cnt_ff <= mm_cnt_in;
      plain_ff  <= plain_in;
      own_ff    <= own_in;
      bad_ff    <= bad_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_plaintext      = plain_ff;
   assign rsp_own_public_key = own_ff;
   assign rsp_secret_invalid = bad_ff;

`ifndef ASSERT_OFF
   a_word_taken: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not make the block busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_plain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (modulus_ff != '0) |->
         (rsp_plaintext < modulus_ff) && (rsp_own_public_key < modulus_ff))
      else $error("result not reduced below modulus");
`endif

endmodule
